// ===== src/pdnr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdnr_pkg;

    // Sizes of the datapath.
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 20;
    localparam int MAG_W        = SUM_W - 1;
    localparam int CHCFG_W      = 4;
    localparam int CH_W         = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W    = $clog2(MAG_W + 1);
    localparam int ALU_W        = 64;
    localparam int RATE_W       = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = RATE_W;

    // Reset values of the configuration registers.
    localparam logic [CHCFG_W-1:0] CHANNELS_RESET = CHCFG_W'(2);
    localparam logic [RATE_W-1:0]  RATE_RESET     = RATE_W'(48000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_SAMPLES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE    = CFG_IDX_W'(3);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_CMP,
        ST_STEP,
        ST_BOUND,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Request to and response from the shared adder.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             cin;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             cout;
    } alu_rsp_t;

    // A channel count of zero acts as one; counts above the maximum saturate.
    function automatic logic [CH_W-1:0] effective_channels(input logic [CHCFG_W-1:0] c);
        logic [CH_W-1:0] r;
        if (c == '0)
        begin
            r = CH_W'(1);
        end
        else if (int'(c) > MAX_CHANNELS)
        begin
            r = CH_W'(MAX_CHANNELS);
        end
        else
        begin
            r = CH_W'(c);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pdnr_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdnr_alu (
    input  wire pdnr_pkg::alu_req_t req,
    output pdnr_pkg::alu_rsp_t      rsp
);

    logic [pdnr_pkg::ALU_W:0] total;

    // One wide adder with carry in; subtraction feeds the inverted operand and a carry.
    always_comb
    begin
        total = {1'b0, req.a} + {1'b0, req.b} + {{pdnr_pkg::ALU_W{1'b0}}, req.cin};
        rsp.sum  = total[pdnr_pkg::ALU_W-1:0];
        rsp.cout = total[pdnr_pkg::ALU_W];
    end

endmodule

`default_nettype wire

// ===== src/pcm_downmix_nearest_resampler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  source_sample, stream_end
// out       output     out_valid/out_ready left_sample, right_sample, last_of_run
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A beat that does not close a frame only accumulates. A beat that closes a frame
// and yields N output beats sends its arithmetic (accumulate, magnitude,
// 19 restoring divide steps, sign, rate compare, phase and boundary steps) through
// one shared 64-bit adder, comparing and stepping per output frame, then emits.
// Reset is immediate, with no clearing pass. A stalled output holds the sequencer
// only while a beat waits in the output register.

module pcm_downmix_nearest_resampler (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [pdnr_pkg::SAMPLE_W-1:0]         source_sample,
    input  wire                                   stream_end,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [pdnr_pkg::SAMPLE_W-1:0]  left_sample,
    output logic signed [pdnr_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                                  last_of_run,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [pdnr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [pdnr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW = pdnr_pkg::ALU_W;
    localparam int SW = pdnr_pkg::SUM_W;
    localparam int MW = pdnr_pkg::MAG_W;
    localparam int CW = pdnr_pkg::CH_W;
    localparam int PW = pdnr_pkg::POS_W;
    localparam int NW = pdnr_pkg::CNT_W;
    localparam int RW = pdnr_pkg::RATE_W;
    localparam int DW = pdnr_pkg::SAMPLE_W;

    // Configuration registers.
    logic [pdnr_pkg::CHCFG_W-1:0] chan_cfg_reg, chan_cfg_next;
    logic                         narrow_reg, narrow_next;
    logic [RW-1:0]                src_rate_reg, src_rate_next;
    logic [RW-1:0]                out_rate_reg, out_rate_next;

    // Stream state.
    logic [PW-1:0]                pos_reg, pos_next;
    logic [SW-1:0]                sum_reg, sum_next;
    logic [AW-1:0]                phase_reg, phase_next;
    logic [AW-1:0]                bound_reg, bound_next;

    // Per-item working registers.
    pdnr_pkg::state_t             state_reg, state_next;
    logic [DW-1:0]                raw_reg, raw_next;
    logic                         end_reg, end_next;
    logic                         neg_reg, neg_next;
    logic [CW-1:0]                div_reg, div_next;
    logic [CW-1:0]                rem_reg, rem_next;
    logic [MW-1:0]                dq_reg, dq_next;
    logic [pdnr_pkg::DIV_CNT_W-1:0] step_reg, step_next;
    logic [DW-1:0]                mono_reg, mono_next;
    logic [NW-1:0]                cnt_reg, cnt_next;

    // Output register.
    logic                         ovalid_reg, ovalid_next;
    logic [DW-1:0]                odata_reg, odata_next;
    logic                         olast_reg, olast_next;

    pdnr_pkg::alu_req_t           alu_req;
    pdnr_pkg::alu_rsp_t           alu_rsp;

    logic [CW-1:0]                chans;
    logic [DW-1:0]                decoded;
    logic [PW:0]                  pos_inc;
    logic [CW:0]                  trial;
    logic                         out_free;

    pdnr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign chans        = pdnr_pkg::effective_channels(chan_cfg_reg);
    assign pos_inc      = {1'b0, pos_reg} + (PW + 1)'(1);
    assign trial        = {rem_reg, dq_reg[MW-1]};
    assign out_free     = !ovalid_reg || out_ready;

    assign in_ready     = (state_reg == pdnr_pkg::ST_IDLE);
    assign cfg_ready    = (state_reg == pdnr_pkg::ST_IDLE);
    assign out_valid    = ovalid_reg;
    assign left_sample  = odata_reg;
    assign right_sample = odata_reg;
    assign last_of_run  = olast_reg;

    // Sample decode: 8-bit unsigned is recentred and moved to the high byte.
    always_comb
    begin
        if (narrow_reg)
        begin
            decoded = {~raw_reg[7], raw_reg[6:0], 8'h00};
        end
        else
        begin
            decoded = raw_reg;
        end
    end

    // Sequencer state, configuration, stream, working and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pdnr_pkg::ST_IDLE;
            chan_cfg_reg <= pdnr_pkg::CHANNELS_RESET;
            narrow_reg   <= 1'b0;
            src_rate_reg <= pdnr_pkg::RATE_RESET;
            out_rate_reg <= pdnr_pkg::RATE_RESET;
            pos_reg      <= '0;
            sum_reg      <= '0;
            phase_reg    <= '0;
            bound_reg    <= AW'(pdnr_pkg::RATE_RESET);
            raw_reg      <= '0;
            end_reg      <= 1'b0;
            neg_reg      <= 1'b0;
            div_reg      <= '0;
            rem_reg      <= '0;
            dq_reg       <= '0;
            step_reg     <= '0;
            mono_reg     <= '0;
            cnt_reg      <= '0;
            ovalid_reg   <= 1'b0;
            odata_reg    <= '0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chan_cfg_reg <= chan_cfg_next;
            narrow_reg   <= narrow_next;
            src_rate_reg <= src_rate_next;
            out_rate_reg <= out_rate_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            phase_reg    <= phase_next;
            bound_reg    <= bound_next;
            raw_reg      <= raw_next;
            end_reg      <= end_next;
            neg_reg      <= neg_next;
            div_reg      <= div_next;
            rem_reg      <= rem_next;
            dq_reg       <= dq_next;
            step_reg     <= step_next;
            mono_reg     <= mono_next;
            cnt_reg      <= cnt_next;
            ovalid_reg   <= ovalid_next;
            odata_reg    <= odata_next;
            olast_reg    <= olast_next;
        end
    end

    // Next state, adder operand selection and register updates.
    always_comb
    begin
        state_next    = state_reg;
        chan_cfg_next = chan_cfg_reg;
        narrow_next   = narrow_reg;
        src_rate_next = src_rate_reg;
        out_rate_next = out_rate_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        phase_next    = phase_reg;
        bound_next    = bound_reg;
        raw_next      = raw_reg;
        end_next      = end_reg;
        neg_next      = neg_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        step_next     = step_reg;
        mono_next     = mono_reg;
        cnt_next      = cnt_reg;
        odata_next    = odata_reg;
        olast_next    = olast_reg;
        alu_req       = '0;

        // The output register drains independently of the sequencer.
        ovalid_next = ovalid_reg && !out_ready;

        unique case (state_reg)
            pdnr_pkg::ST_IDLE:
            begin
                // Configuration writes land only while idle.
                if (cfg_valid)
                begin
                    unique case (cfg_index)
                        pdnr_pkg::REG_CHANNEL_COUNT:
                        begin
                            chan_cfg_next = cfg_data[pdnr_pkg::CHCFG_W-1:0];
                        end
                        pdnr_pkg::REG_NARROW_SAMPLES:
                        begin
                            narrow_next = cfg_data[0];
                        end
                        pdnr_pkg::REG_SOURCE_RATE:
                        begin
                            src_rate_next = cfg_data[RW-1:0];
                        end
                        pdnr_pkg::REG_OUTPUT_RATE:
                        begin
                            out_rate_next = cfg_data[RW-1:0];
                            if (phase_reg == '0)
                            begin
                                bound_next = AW'(cfg_data[RW-1:0]);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (in_valid)
                begin
                    raw_next   = source_sample;
                    end_next   = stream_end;
                    state_next = pdnr_pkg::ST_ACCUM;
                end
            end

            pdnr_pkg::ST_ACCUM:
            begin
                // Add the decoded sample to the running frame sum.
                alu_req.a = {{(AW - SW){sum_reg[SW-1]}}, sum_reg};
                alu_req.b = {{(AW - DW){decoded[DW-1]}}, decoded};
                sum_next  = alu_rsp.sum[SW-1:0];
                if ((CW + 1)'(pos_inc) >= (CW + 1)'(chans))
                begin
                    div_next   = chans;
                    state_next = pdnr_pkg::ST_ABS;
                end
                else
                begin
                    pos_next   = pos_inc[PW-1:0];
                    state_next = pdnr_pkg::ST_FINISH;
                end
            end

            pdnr_pkg::ST_ABS:
            begin
                // Take the magnitude so that the divide truncates toward zero.
                alu_req.a   = '0;
                alu_req.b   = ~{{(AW - SW){sum_reg[SW-1]}}, sum_reg};
                alu_req.cin = 1'b1;
                neg_next    = sum_reg[SW-1];
                dq_next     = sum_reg[SW-1] ? alu_rsp.sum[MW-1:0] : sum_reg[MW-1:0];
                rem_next    = '0;
                step_next   = '0;
                state_next  = pdnr_pkg::ST_DIV;
            end

            pdnr_pkg::ST_DIV:
            begin
                // One restoring divide step: trial subtract of the channel count.
                alu_req.a   = AW'(trial);
                alu_req.b   = ~AW'(div_reg);
                alu_req.cin = 1'b1;
                rem_next    = alu_rsp.cout ? alu_rsp.sum[CW-1:0] : trial[CW-1:0];
                dq_next     = {dq_reg[MW-2:0], alu_rsp.cout};
                step_next   = step_reg + 1'b1;
                if (step_reg == pdnr_pkg::DIV_CNT_W'(MW - 1))
                begin
                    state_next = pdnr_pkg::ST_SIGN;
                end
            end

            pdnr_pkg::ST_SIGN:
            begin
                // Restore the sign of the quotient and close the frame.
                alu_req.a   = '0;
                alu_req.b   = ~AW'(dq_reg);
                alu_req.cin = 1'b1;
                mono_next   = neg_reg ? alu_rsp.sum[DW-1:0] : dq_reg[DW-1:0];
                pos_next    = '0;
                sum_next    = '0;
                cnt_next    = '0;
                state_next  = pdnr_pkg::ST_CMP;
            end

            pdnr_pkg::ST_CMP:
            begin
                // Output frame is due while phase is below the frame boundary.
                alu_req.a   = phase_reg;
                alu_req.b   = ~bound_reg;
                alu_req.cin = 1'b1;
                if ((cnt_reg != NW'(pdnr_pkg::MAX_RESULTS)) && !alu_rsp.cout)
                begin
                    state_next = pdnr_pkg::ST_STEP;
                end
                else
                begin
                    state_next = pdnr_pkg::ST_BOUND;
                end
            end

            pdnr_pkg::ST_STEP:
            begin
                // Advance the phase by one output frame.
                alu_req.a  = phase_reg;
                alu_req.b  = AW'(src_rate_reg);
                phase_next = alu_rsp.sum;
                cnt_next   = cnt_reg + 1'b1;
                state_next = pdnr_pkg::ST_CMP;
            end

            pdnr_pkg::ST_BOUND:
            begin
                // Move the boundary to the end of the next source frame.
                alu_req.a  = bound_reg;
                alu_req.b  = AW'(out_rate_reg);
                bound_next = alu_rsp.sum;
                state_next = pdnr_pkg::ST_EMIT;
            end

            pdnr_pkg::ST_EMIT:
            begin
                // Hand out the counted beats, flagging the final one.
                if (cnt_reg == '0)
                begin
                    state_next = pdnr_pkg::ST_FINISH;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = mono_reg;
                    olast_next  = (cnt_reg == NW'(1));
                    cnt_next    = cnt_reg - 1'b1;
                end
            end

            pdnr_pkg::ST_FINISH:
            begin
                // Stream end restarts all counters after this item's output.
                if (end_reg)
                begin
                    pos_next   = '0;
                    sum_next   = '0;
                    phase_next = '0;
                    bound_next = AW'(out_rate_reg);
                end
                state_next = pdnr_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = pdnr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
